// ===== rtl/core/phta_pkg.sv =====
// ----------------------------------------------------------------------------
// phta_pkg
// Shared types, codes and helpers of the per-host traffic accounting core.
// ----------------------------------------------------------------------------
`default_nettype none

package phta_pkg;

  localparam int unsigned MaxHostsDefault = 64;
  localparam int unsigned MaxNetsDefault  = 4;
  localparam int unsigned NetRegs         = 4;

  // action codes
  localparam logic [1:0] ACT_ACCOUNT = 2'd0;
  localparam logic [1:0] ACT_READ    = 2'd1;
  localparam logic [1:0] ACT_CLEAR   = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NO_INT = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_EMPTY  = 2'd3;

  // protocol numbers
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;
  localparam logic [7:0] PROTO_ICMP = 8'd1;

  // register indexes
  localparam logic [2:0] REG_NET_COUNT = 3'd0;
  localparam logic [2:0] REG_NET0      = 3'd1;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] pkt_len;
    logic [7:0]  protocol;
    logic [5:0]  entry_index;
    logic        scope;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        entry_valid;
    logic [31:0] host_addr;
    logic [31:0] packet_count;
    logic [47:0] sent_bytes;
    logic [47:0] recv_bytes;
    logic [47:0] tcp_bytes;
    logic [47:0] udp_bytes;
    logic [47:0] icmp_bytes;
  } out_word_t;

  // classified word held in the queue
  typedef struct packed {
    in_word_t w;
    logic     src_int;
    logic     dst_int;
  } q_word_t;

  // one host summary
  typedef struct packed {
    logic [31:0] pkt;
    logic [47:0] sent;
    logic [47:0] recv;
    logic [47:0] tcp;
    logic [47:0] udp;
    logic [47:0] icmp;
  } cnt_t;

  typedef enum logic [3:0] {
    BE_INIT, BE_IDLE, BE_SC_RD, BE_SC_CHK, BE_ALLOC, BE_CNT_RD, BE_CNT_UPD,
    BE_RD_SLOT, BE_RD_SCHK, BE_RD_CCHK, BE_CLR, BE_DONE
  } be_state_e;

  function automatic logic [47:0] sat_add48(logic [47:0] v, logic [15:0] d);
    logic [48:0] s;
    s = {1'b0, v} + {33'd0, d};
    return s[48] ? '1 : s[47:0];
  endfunction

  function automatic logic [31:0] sat_inc32(logic [31:0] v);
    return (v == '1) ? v : v + 32'd1;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/per_host_traffic_accounting_core.sv =====
// ----------------------------------------------------------------------------
// per_host_traffic_accounting_core
// Per-host IPv4 traffic accounting with subnet classification and host table.
// ----------------------------------------------------------------------------
// Words are classified against the subnet registers on entry and queued (two
// deep); a sequencer then works through the host table with memories that
// have separate write and read ports and registered read. For each internal
// endpoint an account word reads and checks the slots in turn. A new host
// takes a full linear slot scan, then allocation and the read-modify-write of
// its counters; a host found in a slot ends the scan there. A final state
// hands the result to the output register. A read checks the slot and then
// the counters, a clear sweeps every slot, and a packet with no internal
// endpoint goes straight to that hand-over. Accepted words are registered in
// the queue before the sequencer sees them, and a stalled output holds the
// sequencer before its hand-over. After reset the slot table is swept clear,
// during which input is stalled; configuration writes are taken at any time.
`default_nettype none

module per_host_traffic_accounting_core #(
  parameter int unsigned MAX_HOSTS = phta_pkg::MaxHostsDefault,
  parameter int unsigned MAX_NETS  = phta_pkg::MaxNetsDefault
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [2:0]          cfg_idx_i,
  input  wire logic [63:0]         cfg_wdata_i,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire phta_pkg::in_word_t  in_word_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output phta_pkg::out_word_t      out_word_o
);
  import phta_pkg::*;

  logic    q_full, q_valid, push, pop, busy;
  q_word_t push_word, pop_word;

  // classifier
  phta_front #(.MAX_NETS(MAX_NETS)) u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_o, .in_word_i,
    .q_full_i(q_full), .busy_i(busy), .push_o(push), .push_word_o(push_word)
  );

  // queue
  phta_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(push), .push_word_i(push_word), .full_o(q_full),
    .pop_i(pop), .valid_o(q_valid), .pop_word_o(pop_word)
  );

  // table sequencer
  phta_back #(.MAX_HOSTS(MAX_HOSTS)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_word_i(pop_word), .pop_o(pop),
    .busy_o(busy), .out_valid_o, .out_stall_i, .out_word_o
  );

  // checks
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> q_valid) else $error("pop from empty queue");
  a_stall_in_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> in_stall_o) else $error("input taken during table sweep");
  a_valid_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.entry_valid) |-> (out_word_o.status == ST_OK))
    else $error("valid entry with bad status");

endmodule

`default_nettype wire

// ===== rtl/core/phta_front.sv =====
// ----------------------------------------------------------------------------
// phta_front
// Subnet registers and endpoint classification of incoming words.
// ----------------------------------------------------------------------------
`default_nettype none

module phta_front #(
  parameter int unsigned MAX_NETS = phta_pkg::MaxNetsDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_idx_i,
  input  wire logic [63:0]        cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire phta_pkg::in_word_t in_word_i,
  input  wire logic               q_full_i,
  input  wire logic               busy_i,
  output logic                    push_o,
  output phta_pkg::q_word_t       push_word_o
);
  import phta_pkg::*;

  logic [2:0]  net_count_q;
  logic [63:0] net_cfg_q [NetRegs];

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      net_count_q <= '0;
      for (int i = 0; i < NetRegs; i++) net_cfg_q[i] <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_NET_COUNT) net_count_q <= cfg_wdata_i[2:0];
      for (int i = 0; i < NetRegs; i++) begin
        if (cfg_idx_i == REG_NET0 + 3'(i)) net_cfg_q[i] <= cfg_wdata_i;
      end
    end
  end

  function automatic logic is_internal(logic [31:0] a);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < NetRegs; i++) begin
      if ((32'(i) < 32'(net_count_q)) && (i < MAX_NETS) &&
          ((a & net_cfg_q[i][31:0]) == (net_cfg_q[i][63:32] & net_cfg_q[i][31:0])))
        hit = 1'b1;
    end
    return hit;
  endfunction

  // classify and push
  assign in_stall_o        = q_full_i | busy_i;
  assign push_o            = in_valid_i & ~in_stall_o;
  assign push_word_o.w       = in_word_i;
  assign push_word_o.src_int = is_internal(in_word_i.src_addr);
  assign push_word_o.dst_int = is_internal(in_word_i.dst_addr);

endmodule

`default_nettype wire

// ===== rtl/core/phta_fifo.sv =====
// ----------------------------------------------------------------------------
// phta_fifo
// Two-word queue between the classifier and the table sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module phta_fifo (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire phta_pkg::q_word_t push_word_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output logic                   valid_o,
  output phta_pkg::q_word_t      pop_word_o
);
  import phta_pkg::*;

  q_word_t    mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= push_word_i;
  end

  assign full_o     = cnt_q[1];
  assign valid_o    = (cnt_q != 2'd0);
  assign pop_word_o = mem_q[rp_q];

endmodule

`default_nettype wire

// ===== rtl/core/phta_back.sv =====
// ----------------------------------------------------------------------------
// phta_back
// Host table sequencer: lookup, allocation, counter update, read and clear.
// ----------------------------------------------------------------------------
`default_nettype none

module phta_back #(
  parameter int unsigned MAX_HOSTS = phta_pkg::MaxHostsDefault
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              q_valid_i,
  input  wire phta_pkg::q_word_t q_word_i,
  output logic                   pop_o,
  output logic                   busy_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output phta_pkg::out_word_t    out_word_o
);
  import phta_pkg::*;

  localparam int unsigned SW = (MAX_HOSTS > 1) ? $clog2(MAX_HOSTS) : 1;
  localparam logic [SW-1:0] LastSlot = SW'(MAX_HOSTS - 1);

  be_state_e   state_q, state_d;
  q_word_t     item_q, item_d;
  logic [SW-1:0] scan_q, scan_d, free_q, free_d, slot_q, slot_d;
  logic        ff_q, ff_d, ep_q, ep_d, zb_q, zb_d;
  out_word_t   res_q, res_d, out_q, out_d;
  logic        ov_q, ov_d;

  // memories
  logic [32:0]   slot_mem [MAX_HOSTS];
  cnt_t          cnt_mem [2*MAX_HOSTS];
  logic          slot_we, cnt_we;
  logic [SW-1:0] slot_wa, slot_ra;
  logic [32:0]   slot_wd, slot_rd_q;
  logic [SW:0]   cnt_wa, cnt_ra;
  cnt_t          cnt_wd, cnt_rd_q;

  always_ff @(posedge clk_i) begin
    if (slot_we) slot_mem[slot_wa] <= slot_wd;
    slot_rd_q <= slot_mem[slot_ra];
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
    cnt_rd_q <= cnt_mem[cnt_ra];
  end

  // current endpoint
  logic [31:0] host_a;
  logic        ext;
  logic        used;
  logic        have_free;
  logic [SW-1:0] free_next;
  cnt_t        base;

  assign host_a    = ep_q ? item_q.w.dst_addr : item_q.w.src_addr;
  assign ext       = ep_q ? ~item_q.src_int : ~item_q.dst_int;
  assign used      = slot_rd_q[32];
  assign have_free = ff_q | ~used;
  assign free_next = (!used && !ff_q) ? scan_q : free_q;
  assign base      = zb_q ? '0 : cnt_rd_q;

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BE_INIT;
      scan_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      scan_q  <= scan_d;
      ov_q    <= ov_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    free_q <= free_d;
    slot_q <= slot_d;
    ff_q   <= ff_d;
    ep_q   <= ep_d;
    zb_q   <= zb_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    item_d  = item_q;
    scan_d  = scan_q;
    free_d  = free_q;
    slot_d  = slot_q;
    ff_d    = ff_q;
    ep_d    = ep_q;
    zb_d    = zb_q;
    res_d   = res_q;
    out_d   = out_q;
    ov_d    = ov_q & out_stall_i;
    pop_o   = 1'b0;
    slot_we = 1'b0;
    slot_wa = scan_q;
    slot_wd = '0;
    slot_ra = scan_q;
    cnt_we  = 1'b0;
    cnt_wa  = {slot_q, ext};
    cnt_wd  = '0;
    cnt_ra  = {slot_q, ext};

    unique case (state_q)
      BE_INIT: begin
        slot_we = 1'b1;
        scan_d  = scan_q + SW'(1);
        if (scan_q == LastSlot) begin
          scan_d  = '0;
          state_d = BE_IDLE;
        end
      end
      BE_IDLE: begin
        if (q_valid_i) begin
          pop_o  = 1'b1;
          item_d = q_word_i;
          res_d  = '0;
          scan_d = '0;
          ff_d   = 1'b0;
          unique case (q_word_i.w.action)
            ACT_ACCOUNT: begin
              if (!q_word_i.src_int && !q_word_i.dst_int) begin
                res_d.status = ST_NO_INT;
                state_d      = BE_DONE;
              end else begin
                ep_d    = ~q_word_i.src_int;
                state_d = BE_SC_RD;
              end
            end
            ACT_READ:  state_d = BE_RD_SLOT;
            ACT_CLEAR: state_d = BE_CLR;
            default:   state_d = BE_DONE;
          endcase
        end
      end
      BE_SC_RD: state_d = BE_SC_CHK;
      BE_SC_CHK: begin
        if (used && slot_rd_q[31:0] == host_a) begin
          slot_d  = scan_q;
          zb_d    = 1'b0;
          state_d = BE_CNT_RD;
        end else begin
          free_d = free_next;
          ff_d   = have_free;
          scan_d = scan_q + SW'(1);
          state_d = BE_SC_RD;
          if (scan_q == LastSlot) begin
            scan_d = '0;
            if (have_free) begin
              state_d = BE_ALLOC;
            end else begin
              res_d.status = ST_FULL;
              if (!ep_q && item_q.dst_int) begin
                ep_d    = 1'b1;
                ff_d    = 1'b0;
                state_d = BE_SC_RD;
              end else begin
                state_d = BE_DONE;
              end
            end
          end
        end
      end
      BE_ALLOC: begin
        slot_we = 1'b1;
        slot_wa = free_q;
        slot_wd = {1'b1, host_a};
        cnt_we  = 1'b1;
        cnt_wa  = {free_q, ~ext};
        slot_d  = free_q;
        zb_d    = 1'b1;
        state_d = BE_CNT_RD;
      end
      BE_CNT_RD: state_d = BE_CNT_UPD;
      BE_CNT_UPD: begin
        cnt_we     = 1'b1;
        cnt_wd     = base;
        cnt_wd.pkt = sat_inc32(base.pkt);
        if (item_q.w.src_addr == host_a) cnt_wd.sent = sat_add48(base.sent, item_q.w.pkt_len);
        if (item_q.w.dst_addr == host_a) cnt_wd.recv = sat_add48(base.recv, item_q.w.pkt_len);
        case (item_q.w.protocol)
          PROTO_TCP:  cnt_wd.tcp  = sat_add48(base.tcp, item_q.w.pkt_len);
          PROTO_UDP:  cnt_wd.udp  = sat_add48(base.udp, item_q.w.pkt_len);
          PROTO_ICMP: cnt_wd.icmp = sat_add48(base.icmp, item_q.w.pkt_len);
          default: ;
        endcase
        if (!ep_q && item_q.dst_int) begin
          ep_d    = 1'b1;
          scan_d  = '0;
          ff_d    = 1'b0;
          state_d = BE_SC_RD;
        end else begin
          state_d = BE_DONE;
        end
      end
      BE_RD_SLOT: begin
        slot_ra = SW'(item_q.w.entry_index);
        if (32'(item_q.w.entry_index) >= MAX_HOSTS) begin
          res_d.status = ST_EMPTY;
          state_d      = BE_DONE;
        end else begin
          state_d = BE_RD_SCHK;
        end
      end
      BE_RD_SCHK: begin
        cnt_ra = {SW'(item_q.w.entry_index), item_q.w.scope};
        if (!used) begin
          res_d.status = ST_EMPTY;
          state_d      = BE_DONE;
        end else begin
          res_d.entry_valid = 1'b1;
          res_d.host_addr   = slot_rd_q[31:0];
          state_d           = BE_RD_CCHK;
        end
      end
      BE_RD_CCHK: begin
        res_d.packet_count = cnt_rd_q.pkt;
        res_d.sent_bytes   = cnt_rd_q.sent;
        res_d.recv_bytes   = cnt_rd_q.recv;
        res_d.tcp_bytes    = cnt_rd_q.tcp;
        res_d.udp_bytes    = cnt_rd_q.udp;
        res_d.icmp_bytes   = cnt_rd_q.icmp;
        state_d            = BE_DONE;
      end
      BE_CLR: begin
        slot_we = 1'b1;
        scan_d  = scan_q + SW'(1);
        if (scan_q == LastSlot) begin
          scan_d  = '0;
          state_d = BE_DONE;
        end
      end
      BE_DONE: begin
        if (!ov_d) begin
          out_d   = res_q;
          ov_d    = 1'b1;
          state_d = BE_IDLE;
        end
      end
      default: state_d = BE_IDLE;
    endcase
  end

  assign busy_o      = (state_q == BE_INIT);
  assign out_valid_o = ov_q;
  assign out_word_o  = out_q;

endmodule

`default_nettype wire
